// ===== hw/rtl/bmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP stream decoder package
// Shared types and constants for the header parser and the pixel back end.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ERROR,
        OP_PAL,
        OP_PIX
    } op_t;

    localparam logic [2:0] ST_PIXEL      = 3'd0;
    localparam logic [2:0] ST_NOT_BMP    = 3'd1;
    localparam logic [2:0] ST_BAD_DEPTH  = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd4;
    localparam logic [2:0] ST_NO_PIXEL   = 3'd7;

    localparam logic [31:0] HDR_LEN   = 32'd54;
    localparam logic [31:0] PAL_BYTES = 32'd1024;

    // One work entry handed from the parser to the back end.
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [2:0]  status;
        logic [1:0]  chan;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
    } work_t;

endpackage

// ===== hw/rtl/bmpd_front.sv =====
// ----------------------------------------------------------------------------
// BMP decoder front end
// Parses the header, tracks the file position and classifies every byte.
// ----------------------------------------------------------------------------
module bmpd_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            in_start,
    output logic            wk_valid,
    input  logic            wk_ready,
    output bmpd_pkg::work_t wk
);
    import bmpd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] height_reg, height_next;
    logic [15:0] bpp_reg, bpp_next;
    logic [31:0] off_reg, off_next;
    logic [17:0] pbytes_reg, pbytes_next;
    logic [17:0] llen_reg, llen_next;
    logic [17:0] bil_reg, bil_next;
    logic [1:0]  k3_reg, k3_next;
    logic [11:0] col_reg, col_next;
    logic [31:0] line_reg, line_next;
    logic        vld_reg, vld_next;
    work_t       wk_reg, wk_next;

    phase_t      ph;
    logic [31:0] cnt, width, height, off, pos, lc, minoff;
    logic [15:0] bpp;
    logic [17:0] pb, bil;
    logic [1:0]  k3;
    logic [1:0]  bsel;
    logic [11:0] colv;
    logic        take;
    logic        emit;

    assign in_ready = !vld_reg || wk_ready;
    assign take     = in_valid && in_ready;
    assign wk_valid = vld_reg;
    assign wk       = wk_reg;

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        off_next    = off_reg;
        pbytes_next = pbytes_reg;
        llen_next   = llen_reg;
        bil_next    = bil_reg;
        k3_next     = k3_reg;
        col_next    = col_reg;
        line_next   = line_reg;
        vld_next    = vld_reg && !wk_ready;
        wk_next     = wk_reg;
        ph     = phase_reg;
        cnt    = cnt_reg;
        width  = width_reg;
        height = height_reg;
        bpp    = bpp_reg;
        off    = off_reg;
        pb     = pbytes_reg;
        bil    = bil_reg;
        k3     = k3_reg;
        colv   = col_reg;
        lc     = line_reg;
        pos    = 32'd0;
        minoff = 32'd0;
        bsel   = 2'd0;
        emit   = 1'b0;
        if (take) begin
            if (in_start) begin
                ph = PH_HEADER; cnt = '0; width = '0; height = '0; bpp = '0;
                off = '0; pb = '0; bil = '0; k3 = '0; colv = '0; lc = '0;
                llen_next = '0;
            end
            wk_next.op     = OP_NONE;
            wk_next.data   = in_byte;
            wk_next.status = ST_PIXEL;
            wk_next.chan   = 2'd0;
            wk_next.column = '0;
            wk_next.row    = '0;
            wk_next.last   = 1'b0;
            unique case (ph)
                PH_HEADER: begin
                    if ((cnt == 32'd0 && in_byte != 8'h42) ||
                        (cnt == 32'd1 && in_byte != 8'h4D)) begin
                        wk_next.op = OP_ERROR; wk_next.status = ST_NOT_BMP;
                        ph = PH_ERROR;
                    end else begin
                        bsel = cnt[1:0] - 2'd2;
                        if (cnt >= 32'd10 && cnt <= 32'd13)
                            off[8*bsel +: 8] = in_byte;
                        else if (cnt >= 32'd18 && cnt <= 32'd21)
                            width[8*bsel +: 8] = in_byte;
                        else if (cnt >= 32'd22 && cnt <= 32'd25)
                            height[8*bsel +: 8] = in_byte;
                        else if (cnt == 32'd28)
                            bpp[7:0] = in_byte;
                        else if (cnt == 32'd29)
                            bpp[15:8] = in_byte;
                        if (cnt == HDR_LEN - 32'd1) begin
                            minoff = (bpp == 16'd8) ? HDR_LEN + PAL_BYTES : HDR_LEN;
                            pb = (bpp == 16'd8) ? width[17:0] : 18'(width * 32'd3);
                            llen_next = (pb + 18'd3) & ~18'd3;
                            if (bpp != 16'd8 && bpp != 16'd24) begin
                                wk_next.op = OP_ERROR; wk_next.status = ST_BAD_DEPTH;
                                ph = PH_ERROR;
                            end else if (width > 32'(MAX_WIDTH) ||
                                         height > 32'(MAX_HEIGHT)) begin
                                wk_next.op = OP_ERROR; wk_next.status = ST_TOO_LARGE;
                                ph = PH_ERROR;
                            end else if (off < minoff) begin
                                wk_next.op = OP_ERROR; wk_next.status = ST_BAD_OFFSET;
                                ph = PH_ERROR;
                            end else if (width == '0 || height == '0)
                                ph = PH_DONE;
                            else if (bpp == 16'd8)
                                ph = PH_PALETTE;
                            else
                                ph = (off == HDR_LEN) ? PH_PIXELS : PH_SKIP;
                        end
                        cnt = cnt + 32'd1;
                    end
                end
                PH_PALETTE: begin
                    pos = cnt - HDR_LEN;
                    wk_next.op     = (pos[1:0] != 2'd3) ? OP_PAL : OP_NONE;
                    wk_next.chan   = pos[1:0];
                    wk_next.column = {4'd0, pos[9:2]};
                    if (pos == PAL_BYTES - 32'd1)
                        ph = (cnt + 32'd1 == off) ? PH_PIXELS : PH_SKIP;
                    cnt = cnt + 32'd1;
                end
                PH_SKIP: begin
                    if (cnt + 32'd1 == off) ph = PH_PIXELS;
                    cnt = cnt + 32'd1;
                end
                PH_PIXELS: begin
                    if (bil < pb) begin
                        if (bpp == 16'd8) begin
                            emit = 1'b1;
                            wk_next.chan = 2'd3;
                        end else begin
                            wk_next.chan = k3;
                            emit = (k3 == 2'd2);
                        end
                        wk_next.column = (bpp == 16'd8) ? bil[11:0] : colv;
                        wk_next.row    = 12'(height - 32'd1 - lc);
                        wk_next.last   = (lc == height - 32'd1) &&
                            (32'(wk_next.column) == width - 32'd1);
                        wk_next.op     = OP_PIX;
                        if (k3 == 2'd2) begin
                            k3 = 2'd0; colv = colv + 12'd1;
                        end else
                            k3 = k3 + 2'd1;
                    end
                    wk_next.status = emit ? ST_PIXEL : ST_NO_PIXEL;
                    bil = bil + 18'd1;
                    if (bil >= llen_next) begin
                        bil = '0; k3 = '0; colv = '0;
                        lc = lc + 32'd1;
                        if (lc >= height) ph = PH_DONE;
                    end
                    cnt = cnt + 32'd1;
                end
                default: ;
            endcase
            vld_next    = (wk_next.op != OP_NONE);
            phase_next  = ph;
            cnt_next    = cnt;
            width_next  = width;
            height_next = height;
            bpp_next    = bpp;
            off_next    = off;
            pbytes_next = pb;
            bil_next    = bil;
            k3_next     = k3;
            col_next    = colv;
            line_next   = lc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER; cnt_reg <= '0; width_reg <= '0;
            height_reg <= '0; bpp_reg <= '0; off_reg <= '0; pbytes_reg <= '0;
            llen_reg <= '0; bil_reg <= '0; k3_reg <= '0; col_reg <= '0;
            line_reg <= '0; vld_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; width_reg <= width_next;
            height_reg <= height_next; bpp_reg <= bpp_next; off_reg <= off_next;
            pbytes_reg <= pbytes_next; llen_reg <= llen_next; bil_reg <= bil_next;
            k3_reg <= k3_next; col_reg <= col_next; line_reg <= line_next;
            vld_reg <= vld_next;
        end
        wk_reg <= wk_next;
    end
endmodule

// ===== hw/rtl/bmpd_back.sv =====
// ----------------------------------------------------------------------------
// BMP decoder back end
// Writes the palette, assembles pixels and holds the result in an output register.
// ----------------------------------------------------------------------------
module bmpd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wk_valid,
    output logic            wk_ready,
    input  bmpd_pkg::work_t wk,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [51:0]     out_data
);
    import bmpd_pkg::*;

    logic [23:0] pal_mem [256];
    logic [7:0]  pb_reg, pg_reg;
    logic        rd_reg;
    work_t       rw_reg;
    logic [23:0] pal_q;
    logic [15:0] bg_reg;
    logic        ov_reg;
    logic [51:0] od_reg;
    logic        s1_ready;
    logic        s1_take;
    logic [23:0] rgb;

    // Stage 1 reads the palette; stage 2 is the output register.
    assign s1_ready = !ov_reg || out_ready;
    assign wk_ready = !rd_reg || s1_ready;
    assign s1_take  = wk_valid && wk_ready;

    always_ff @(posedge aclk) begin
        if (wk_valid && wk_ready && wk.op == OP_PAL) begin
            unique case (wk.chan)
                2'd0:    pal_mem[wk.column[7:0]][7:0]   <= wk.data;
                2'd1:    pal_mem[wk.column[7:0]][15:8]  <= wk.data;
                default: pal_mem[wk.column[7:0]][23:16] <= wk.data;
            endcase
        end
        if (s1_take)
            pal_q <= pal_mem[wk.data];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            if (s1_take)
                rd_reg <= (wk.op == OP_ERROR) ||
                          (wk.op == OP_PIX && wk.status == ST_PIXEL);
            else if (s1_ready)
                rd_reg <= 1'b0;
            if (rd_reg && s1_ready)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
        if (s1_take) begin
            rw_reg <= wk;
            if (wk.op == OP_PIX && wk.chan == 2'd0) pb_reg <= wk.data;
            if (wk.op == OP_PIX && wk.chan == 2'd1) pg_reg <= wk.data;
            bg_reg <= {pg_reg, pb_reg};
        end
        if (rd_reg && s1_ready)
            od_reg <= {rw_reg.status, rw_reg.last, rw_reg.row, rw_reg.column,
                       rgb[7:0], rgb[15:8], rgb[23:16]};
    end

    always_comb begin
        if (rw_reg.op == OP_ERROR)
            rgb = '0;
        else if (rw_reg.chan == 2'd3)
            rgb = pal_q;
        else
            rgb = {rw_reg.data, bg_reg};
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
endmodule

// ===== hw/rtl/bmp_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// BMP stream decoder
// Decodes 8-bit palette and 24-bit BMP files delivered one byte per request.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_axis   in         tdata[7:0] data_byte, tuser file_start
// m_axis   out        tdata red, green, blue, column, row; tlast; tuser status
//
// One byte is accepted every cycle; results pass the work, palette and
// output registers. The parser updates its counters once per byte, and the
// palette memory adds one registered read. Reset is synchronous and active
// low. A stall on the output holds the back end and then the parser.
// ----------------------------------------------------------------------------
module bmp_stream_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // file_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // red, green, blue, column, row
    output logic        m_axis_tlast,   // last_pixel
    output logic [2:0]  m_axis_tuser    // status
);
    import bmpd_pkg::*;

    logic        wk_valid, wk_ready;
    work_t       wk;
    logic [51:0] od;

    bmpd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_byte(s_axis_tdata), .in_start(s_axis_tuser),
        .wk_valid(wk_valid), .wk_ready(wk_ready), .wk(wk)
    );

    bmpd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .wk_valid(wk_valid), .wk_ready(wk_ready), .wk(wk),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
    );

    assign m_axis_tdata = od[47:0];
    assign m_axis_tlast = od[48];
    assign m_axis_tuser = od[51:49];
endmodule

// ===== hw/rtl/bmpd_checker.sv =====
// ----------------------------------------------------------------------------
// BMP decoder port checker
// Watches the top-level ports for result consistency.
// ----------------------------------------------------------------------------
module bmpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser
);
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != 3'd0 |-> m_axis_tdata == '0 && !m_axis_tlast)
        else $error("Error result carries pixel data.");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= 3'd4)
        else $error("Status code out of range.");
endmodule

bind bmp_stream_decoder bmpd_checker u_checker (.*);
